### hw/rtl/hsml_pkg.sv
// Shared types and constants of the hex stream memory loader.
package hsml_pkg;

    localparam int          PROGRESS_SHIFT = 10;
    localparam logic [31:0] RESET_START    = 32'h0001_0000;

    // APB register map: one register, byte address 0.
    localparam int         CFG_ADDR_W        = 2;
    localparam logic [1:0] REG_START_ADDRESS = 2'd0;

    // Command queue between parser and sequencer.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Output kinds.
    localparam logic KIND_WRITE   = 1'b0;
    localparam logic KIND_CONSOLE = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_RUN,
        CMD_ECHO1,
        CMD_ECHO2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        dot;
        logic [31:0] addr;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
    } cmd_t;

    typedef struct packed {
        logic        wr;
        logic [31:0] data;
    } cfg_wr_t;

endpackage

### hw/rtl/hsml_front.sv
// Character parser: classifies each item and, where one is due, queues a command for the sequencer.
module hsml_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  hsml_pkg::cfg_wr_t cfg_i,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // [7:0] rx_char
    input  logic            full_i,
    output logic            push_o,
    output hsml_pkg::cmd_t  cmd_o
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ADDR,
        MODE_PAIR,
        MODE_HALT
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] count_reg, count_next;
    logic [7:0]  pend_reg, pend_next;

    logic        accept;
    logic        is_hex;
    logic [3:0]  digit;
    logic [3:0]  pend_digit;
    logic        is_space;
    logic        dot;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = hex_decode(c);
        return r[3:0];
    endfunction

    assign s_tready   = !full_i;
    assign accept     = s_tvalid && s_tready;
    assign {is_hex, digit} = hex_decode(s_tdata);
    assign pend_digit = hex_digit(pend_reg);
    assign is_space   = (s_tdata == 8'h20) || (s_tdata == 8'h09) ||
                        (s_tdata == 8'h0D) || (s_tdata == 8'h0A);
    assign dot        = (count_reg[hsml_pkg::PROGRESS_SHIFT-1:0] == '0);

    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        push_o     = 1'b0;
        cmd_o.op   = hsml_pkg::CMD_WRITE;
        cmd_o.dot  = 1'b0;
        cmd_o.addr = base_reg + count_reg;
        cmd_o.ch0  = pend_reg;
        cmd_o.ch1  = s_tdata;
        if (accept) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (s_tdata == 8'h00) begin
                        push_o    = 1'b1;
                        cmd_o.op  = hsml_pkg::CMD_RUN;
                        mode_next = MODE_HALT;
                    end else if (s_tdata == 8'h40) begin
                        acc_next  = '0;
                        mode_next = MODE_ADDR;
                    end else if (is_hex) begin
                        pend_next = s_tdata;
                        mode_next = MODE_PAIR;
                    end else if (!is_space) begin
                        push_o   = 1'b1;
                        cmd_o.op = hsml_pkg::CMD_ECHO1;
                    end
                end
                MODE_ADDR: begin
                    if (is_hex) begin
                        acc_next = {acc_reg[27:0], digit};
                    end else begin
                        base_next  = acc_reg;
                        count_next = '0;
                        mode_next  = MODE_IDLE;
                    end
                end
                MODE_PAIR: begin
                    push_o = 1'b1;
                    if (is_hex) begin
                        cmd_o.op   = hsml_pkg::CMD_WRITE;
                        cmd_o.dot  = dot;
                        cmd_o.ch1  = {pend_digit, digit};
                        count_next = count_reg + 32'd1;
                    end else begin
                        cmd_o.op = hsml_pkg::CMD_ECHO2;
                    end
                    mode_next = MODE_IDLE;
                end
                MODE_HALT: begin
                end
                default: begin
                end
            endcase
        end
        if (cfg_i.wr) begin
            base_next = cfg_i.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            base_reg  <= hsml_pkg::RESET_START;
            count_reg <= '0;
            pend_reg  <= '0;
        end else begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### hw/rtl/hsml_cmd_fifo.sv
// Two-entry command queue between parser and sequencer.
module hsml_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_i,
    input  hsml_pkg::cmd_t cmd_i,
    input  logic           pop_i,
    output hsml_pkg::cmd_t cmd_o,
    output logic           full_o,
    output logic           empty_o
);

    hsml_pkg::cmd_t                     slot_reg [hsml_pkg::QUEUE_DEPTH];
    logic [hsml_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [hsml_pkg::QUEUE_CNT_W-1:0]   cnt_reg, cnt_next;

    assign full_o  = (cnt_reg == hsml_pkg::QUEUE_CNT_W'(hsml_pkg::QUEUE_DEPTH));
    assign empty_o = (cnt_reg == '0);
    assign cmd_o   = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push_i && !pop_i) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop_i && !push_i) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            slot_reg[wr_ptr_reg] <= cmd_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            // advance pointers; depth is a power of two so they wrap
            if (push_i) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_i) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### hw/rtl/hsml_back.sv
// Result sequencer: expands each queued command into result items.
module hsml_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           empty_i,
    input  hsml_pkg::cmd_t cmd_i,
    output logic           pop_o,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,   // [31:0] write_address, [39:32] byte_value
    output logic [1:0]     m_tuser,   // [0] out_kind, [1] start_program
    output logic           m_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t         state_reg;
    hsml_pkg::cmd_t cmd_reg;
    logic [3:0]     pos_reg;
    logic           valid_reg;
    logic [39:0]    data_reg;
    logic [1:0]     user_reg;
    logic           last_reg;

    logic [3:0]     start_pos;
    logic [3:0]     end_pos;
    logic           out_free;
    logic           load_out;
    logic           it_kind;
    logic [31:0]    it_addr;
    logic [7:0]     it_byte;
    logic           it_start;

    function automatic logic [7:0] prompt_char(input logic [3:0] i);
        logic [7:0] c;
        case (i)
            4'd0:    c = 8'h42;  // B
            4'd1:    c = 8'h6F;  // o
            4'd2:    c = 8'h6F;  // o
            4'd3:    c = 8'h74;  // t
            4'd4:    c = 8'h6C;  // l
            4'd5:    c = 8'h6F;  // o
            4'd6:    c = 8'h61;  // a
            4'd7:    c = 8'h64;  // d
            4'd8:    c = 8'h65;  // e
            4'd9:    c = 8'h72;  // r
            4'd10:   c = 8'h3E;  // >
            default: c = 8'h20;  // space
        endcase
        return c;
    endfunction

    function automatic logic [7:0] run_char(input logic [1:0] i);
        logic [7:0] c;
        case (i)
            2'd0:    c = 8'h52;  // R
            2'd1:    c = 8'h55;  // U
            2'd2:    c = 8'h4E;  // N
            default: c = 8'h0A;  // newline
        endcase
        return c;
    endfunction

    // first position of each command, from the queue head
    always_comb begin
        case (cmd_i.op)
            hsml_pkg::CMD_WRITE: start_pos = cmd_i.dot ? 4'd0 : 4'd1;
            hsml_pkg::CMD_ECHO1: start_pos = 4'd1;
            default:             start_pos = 4'd0;
        endcase
    end

    // last position and the item at the current position
    always_comb begin
        it_kind  = hsml_pkg::KIND_CONSOLE;
        it_addr  = '0;
        it_byte  = 8'h00;
        it_start = 1'b0;
        case (cmd_reg.op)
            hsml_pkg::CMD_WRITE: begin
                end_pos = 4'd1;
                if (pos_reg == 4'd0) begin
                    it_byte = 8'h2E;  // progress mark
                end else begin
                    it_kind = hsml_pkg::KIND_WRITE;
                    it_addr = cmd_reg.addr;
                    it_byte = cmd_reg.ch1;
                end
            end
            hsml_pkg::CMD_RUN: begin
                end_pos  = 4'd3;
                it_byte  = run_char(pos_reg[1:0]);
                it_start = (pos_reg == 4'd3);
            end
            default: begin
                end_pos = 4'd14;
                if (pos_reg == 4'd0) begin
                    it_byte = cmd_reg.ch0;
                end else if (pos_reg == 4'd1) begin
                    it_byte = cmd_reg.ch1;
                end else if (pos_reg == 4'd2) begin
                    it_byte = 8'h0A;
                end else begin
                    it_byte = prompt_char(pos_reg - 4'd3);
                end
            end
        endcase
    end

    assign out_free = !valid_reg || m_tready;
    assign load_out = (state_reg == ST_EMIT) && out_free;
    assign pop_o    = (state_reg == ST_IDLE) && !empty_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!empty_i) begin
                        pos_reg   <= start_pos;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (pos_reg == end_pos) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg <= pos_reg + 4'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers: command latch and output stage
    always_ff @(posedge aclk) begin
        if (pop_o) begin
            cmd_reg <= cmd_i;
        end
        if (load_out) begin
            data_reg <= {it_byte, it_addr};
            user_reg <= {it_start, it_kind};
            last_reg <= (pos_reg == end_pos);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

### hw/rtl/hex_stream_memory_loader_top.sv
// Top level of the hex stream memory loader: APB register, parser, queue, sequencer.
// With queue and sequencer idle, the first result of an item passes the command queue,
// the sequencer's fetch of the command (ST_IDLE) and then the output register.
// Throughput: s_ takes one item a cycle while the two-entry command queue has room;
// the sequencer fetches each command in ST_IDLE, then gives one result a cycle while
// m_tready allows (1 to 15 results), and fetches the next only after the last result.
// Reset (aresetn low, synchronous): parser idle, queue and output stage empty,
// start_address and the load base back to 0x00010000.
module hex_stream_memory_loader_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsml_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream of console characters
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_char
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [31:0] write_address, [39:32] byte_value
    output logic [1:0]                    m_tuser,   // [0] out_kind, [1] start_program
    output logic                          m_tlast
);

    logic [31:0]       start_reg;
    hsml_pkg::cfg_wr_t cfg;
    logic              push;
    hsml_pkg::cmd_t    push_cmd;
    hsml_pkg::cmd_t    head_cmd;
    logic              pop;
    logic              full;
    logic              empty;

    // APB: zero wait states; a write lands on the access cycle
    assign pready   = 1'b1;
    assign cfg.wr   = psel && penable && pwrite && (paddr == hsml_pkg::REG_START_ADDRESS);
    assign cfg.data = pwdata;
    assign prdata   = (paddr == hsml_pkg::REG_START_ADDRESS) ? start_reg : 32'd0;

    // hold the start address for readback; the parser reloads its base on the same write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= hsml_pkg::RESET_START;
        end else if (cfg.wr) begin
            start_reg <= cfg.data;
        end
    end

    // front: classify characters, track address and count, queue commands
    hsml_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_i    (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .full_i   (full),
        .push_o   (push),
        .cmd_o    (push_cmd)
    );

    // queue: lets the parser keep taking items while results drain
    hsml_cmd_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .cmd_i   (push_cmd),
        .pop_i   (pop),
        .cmd_o   (head_cmd),
        .full_o  (full),
        .empty_o (empty)
    );

    // back: expand each command into writes and console characters
    hsml_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty_i  (empty),
        .cmd_i    (head_cmd),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
